// ===== hdl/slbm_pkg.sv =====
package slbm_pkg;

  // width of the running loss total
  localparam int unsigned LOSS_BITS = 40;

  // width of the bin index field on the input side
  localparam int unsigned BIN_IDX_BITS = 6;

  // entries in the queue between classifier and update engine
  localparam int unsigned Q_DEPTH = 4;

  // what the classifier decided about one transaction
  typedef struct packed {
    logic rd;      // histogram read request
    logic late;    // packet at or below the in-order mark
    logic gap;     // packet revealed a loss burst
    logic bin_ok;  // read request names an existing bin
  } slbm_kind_t;

endpackage

// ===== hdl/slbm_front.sv =====
module slbm_front #(
  parameter int unsigned SEQ_BITS  = 32,
  parameter int unsigned HIST_BINS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 take,
  input  logic                                 mode,
  input  logic [SEQ_BITS-1:0]                  seq_number,
  input  logic [slbm_pkg::BIN_IDX_BITS-1:0]    bin_index,
  output slbm_pkg::slbm_kind_t                 rec_kind,
  output logic [SEQ_BITS-1:0]                  rec_start,
  output logic [SEQ_BITS-1:0]                  rec_len,
  output logic [$clog2(HIST_BINS)-1:0]         rec_bin
);

  localparam int unsigned IDX_W    = $clog2(HIST_BINS);
  localparam int unsigned LAST_BIN = HIST_BINS - 1;

  logic [SEQ_BITS-1:0]                       last_in_order;
  logic [SEQ_BITS-1:0]                       last_in_order_next;
  logic [SEQ_BITS-1:0]                       lost_n;
  logic [SEQ_BITS-1:0]                       expected;
  logic [63:0]                               lost_wide;
  logic [IDX_W+slbm_pkg::BIN_IDX_BITS-1:0]   idx_wide;
  logic                                      is_late;
  logic                                      is_gap;

  // seq - (last + 1) in one adder
  assign lost_n    = seq_number + ~last_in_order;
  assign expected  = last_in_order + SEQ_BITS'(1);
  assign lost_wide = 64'(lost_n);
  assign idx_wide  = (IDX_W + slbm_pkg::BIN_IDX_BITS)'(bin_index);

  assign is_late = !mode && (seq_number <= last_in_order);
  assign is_gap  = !mode && !is_late && (lost_n != '0);

  always_comb begin
    rec_kind.rd     = mode;
    rec_kind.late   = is_late;
    rec_kind.gap    = is_gap;
    rec_kind.bin_ok = 32'(bin_index) < 32'(HIST_BINS);
    rec_start       = is_gap ? expected : '0;
    rec_len         = is_gap ? lost_n : '0;
    if (mode) begin
      rec_bin = idx_wide[IDX_W-1:0];
    end else if (lost_wide >= 64'(LAST_BIN)) begin
      rec_bin = IDX_W'(LAST_BIN);
    end else begin
      rec_bin = lost_wide[IDX_W-1:0];
    end
    last_in_order_next = last_in_order;
    if (take && !mode && !is_late) begin
      last_in_order_next = seq_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_in_order <= '0;
    end else begin
      last_in_order <= last_in_order_next;
    end
  end

endmodule

// ===== hdl/slbm_queue.sv =====
module slbm_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_full,
  output logic             q_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/slbm_back.sv =====
module slbm_back #(
  parameter int unsigned SEQ_BITS   = 32,
  parameter int unsigned HIST_BINS  = 64,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // head of the queue
  input  logic                              q_valid,
  input  slbm_pkg::slbm_kind_t              q_kind,
  input  logic [SEQ_BITS-1:0]               q_start,
  input  logic [SEQ_BITS-1:0]               q_len,
  input  logic [$clog2(HIST_BINS)-1:0]      q_bin,
  output logic                              q_pop,
  output logic                              clr_busy,
  // result side
  input  logic                              pop,
  output logic                              empty,
  output logic                              gap_found,
  output logic                              late_arrival,
  output logic [SEQ_BITS-1:0]               gap_start_seq,
  output logic [SEQ_BITS-1:0]               gap_length,
  output logic [slbm_pkg::LOSS_BITS-1:0]    lost_total,
  output logic [COUNT_BITS-1:0]             gaps_seen,
  output logic [COUNT_BITS-1:0]             bin_count
);

  localparam int unsigned IDX_W    = $clog2(HIST_BINS);
  localparam int unsigned LAST_BIN = HIST_BINS - 1;
  localparam int unsigned SUM_W    =
    ((SEQ_BITS > slbm_pkg::LOSS_BITS) ? SEQ_BITS : slbm_pkg::LOSS_BITS) + 1;

  logic [COUNT_BITS-1:0]            hist [HIST_BINS];
  logic [IDX_W-1:0]                 clr_idx;

  logic                             s2_valid;
  slbm_pkg::slbm_kind_t             s2_kind;
  logic [SEQ_BITS-1:0]              s2_start;
  logic [SEQ_BITS-1:0]              s2_len;
  logic [IDX_W-1:0]                 s2_bin;
  logic [COUNT_BITS-1:0]            rd_raw;
  logic                             fwd_hit;
  logic [COUNT_BITS-1:0]            fwd_data;

  logic                             out_valid;
  logic [slbm_pkg::LOSS_BITS-1:0]   loss_sum;
  logic [COUNT_BITS-1:0]            burst_count;

  logic                             s2_adv;
  logic                             hist_we;
  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_waddr;
  logic [COUNT_BITS-1:0]            mem_wdata;
  logic [COUNT_BITS-1:0]            bin_cur;
  logic [COUNT_BITS-1:0]            bin_inc;
  logic [SUM_W-1:0]                 loss_wide;
  logic [slbm_pkg::LOSS_BITS-1:0]   loss_sum_next;
  logic [COUNT_BITS-1:0]            burst_count_next;

  assign s2_adv  = s2_valid && (!out_valid || pop);
  assign q_pop   = q_valid && !clr_busy && (!s2_valid || s2_adv);
  assign hist_we = s2_adv && s2_kind.gap;
  assign empty   = !out_valid;

  // bin value with bypass of the write that landed as this read was issued
  assign bin_cur = fwd_hit ? fwd_data : rd_raw;
  assign bin_inc = (&bin_cur) ? bin_cur : bin_cur + COUNT_BITS'(1);

  assign loss_wide = SUM_W'(loss_sum) + SUM_W'(s2_len);
  assign loss_sum_next = (loss_wide > SUM_W'({slbm_pkg::LOSS_BITS{1'b1}}))
                         ? {slbm_pkg::LOSS_BITS{1'b1}}
                         : loss_wide[slbm_pkg::LOSS_BITS-1:0];
  assign burst_count_next = (&burst_count) ? burst_count
                                           : burst_count + COUNT_BITS'(1);

  // single write port: clearing pass or burst update
  assign mem_we    = clr_busy || hist_we;
  assign mem_waddr = clr_busy ? clr_idx : s2_bin;
  assign mem_wdata = clr_busy ? '0 : bin_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rd_raw <= hist[q_bin];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_kind  <= q_kind;
      s2_start <= q_start;
      s2_len   <= q_len;
      s2_bin   <= q_bin;
      fwd_hit  <= hist_we && (s2_bin == q_bin);
      fwd_data <= bin_inc;
    end
    if (s2_adv) begin
      gap_found     <= s2_kind.gap;
      late_arrival  <= s2_kind.late;
      gap_start_seq <= s2_start;
      gap_length    <= s2_len;
      lost_total    <= s2_kind.gap ? loss_sum_next : loss_sum;
      gaps_seen     <= s2_kind.gap ? burst_count_next : burst_count;
      bin_count     <= (s2_kind.rd && s2_kind.bin_ok) ? bin_cur : '0;
    end
  end

  // control and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy    <= 1'b1;
      clr_idx     <= '0;
      s2_valid    <= 1'b0;
      out_valid   <= 1'b0;
      loss_sum    <= '0;
      burst_count <= '0;
    end else begin
      if (clr_busy) begin
        clr_idx <= clr_idx + IDX_W'(1);
        if (clr_idx == IDX_W'(LAST_BIN)) begin
          clr_busy <= 1'b0;
        end
      end
      if (q_pop) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (hist_we) begin
        loss_sum    <= loss_sum_next;
        burst_count <= burst_count_next;
      end
    end
  end

  // nothing moves through the pipe while the histogram is being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> (!q_pop && !s2_valid && !out_valid))
    else $error("pipeline active during histogram clear");

  // clearing pass and burst update never compete for the write port
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !hist_we)
    else $error("histogram write port conflict");

  a_bursts_rise: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (burst_count >= $past(burst_count)))
    else $error("burst counter went backward");

  a_loss_rises: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (loss_sum >= $past(loss_sum)))
    else $error("loss total went backward");

endmodule

// ===== hdl/sequence_loss_burst_monitor.sv =====
// channel  | ports                                         | handshake
// ---------+-----------------------------------------------+---------------------------
// input    | mode, seq_number, bin_index                   | push && !full
// result   | gap_found, late_arrival, gap_start_seq,       | pop && !empty
//          | gap_length, lost_total, gaps_seen, bin_count  |
//
// one transaction per cycle sustained while full is low and results are popped; a result
// passes through the queue, the s2 stage registers and the result register before it shows on the ports
// after rst the histogram memory is cleared one bin a cycle, every bin in turn,
// with full held high; the pipeline is empty when that pass ends
// a stalled result side fills the four-entry queue, then full rises
// each input transaction gives exactly one result, in order
module sequence_loss_burst_monitor #(
  parameter int unsigned SEQ_BITS   = 32,
  parameter int unsigned HIST_BINS  = 64,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              mode,
  input  logic [SEQ_BITS-1:0]               seq_number,
  input  logic [slbm_pkg::BIN_IDX_BITS-1:0] bin_index,
  input  logic                              pop,
  output logic                              empty,
  output logic                              gap_found,
  output logic                              late_arrival,
  output logic [SEQ_BITS-1:0]               gap_start_seq,
  output logic [SEQ_BITS-1:0]               gap_length,
  output logic [slbm_pkg::LOSS_BITS-1:0]    lost_total,
  output logic [COUNT_BITS-1:0]             gaps_seen,
  output logic [COUNT_BITS-1:0]             bin_count
);

  localparam int unsigned IDX_W  = $clog2(HIST_BINS);
  localparam int unsigned KIND_W = $bits(slbm_pkg::slbm_kind_t);
  // queue entry: kind, gap start, gap length, bin
  localparam int unsigned REC_W  = KIND_W + 2 * SEQ_BITS + IDX_W;

  logic                   take;
  logic                   q_full;
  logic                   q_empty;
  logic                   q_pop;
  logic                   clr_busy;

  slbm_pkg::slbm_kind_t   f_kind;
  logic [SEQ_BITS-1:0]    f_start;
  logic [SEQ_BITS-1:0]    f_len;
  logic [IDX_W-1:0]       f_bin;

  logic [REC_W-1:0]       q_wdata;
  logic [REC_W-1:0]       q_rdata;
  slbm_pkg::slbm_kind_t   h_kind;
  logic [SEQ_BITS-1:0]    h_start;
  logic [SEQ_BITS-1:0]    h_len;
  logic [IDX_W-1:0]       h_bin;

  // no input taken while the queue is full or the histogram is still clearing
  assign full = q_full || clr_busy;
  assign take = push && !full;

  // front: checks the number against the in-order mark and sorts the transaction
  slbm_front #(
    .SEQ_BITS  (SEQ_BITS),
    .HIST_BINS (HIST_BINS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .mode       (mode),
    .seq_number (seq_number),
    .bin_index  (bin_index),
    .rec_kind   (f_kind),
    .rec_start  (f_start),
    .rec_len    (f_len),
    .rec_bin    (f_bin)
  );

  assign q_wdata = {f_kind, f_start, f_len, f_bin};
  assign {h_kind, h_start, h_len, h_bin} = q_rdata;

  // short queue decoupling the sorter from the counter update
  slbm_queue #(
    .WIDTH (REC_W),
    .DEPTH (slbm_pkg::Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // back: histogram read-modify-write, loss and burst totals, result register
  slbm_back #(
    .SEQ_BITS   (SEQ_BITS),
    .HIST_BINS  (HIST_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (!q_empty),
    .q_kind        (h_kind),
    .q_start       (h_start),
    .q_len         (h_len),
    .q_bin         (h_bin),
    .q_pop         (q_pop),
    .clr_busy      (clr_busy),
    .pop           (pop),
    .empty         (empty),
    .gap_found     (gap_found),
    .late_arrival  (late_arrival),
    .gap_start_seq (gap_start_seq),
    .gap_length    (gap_length),
    .lost_total    (lost_total),
    .gaps_seen     (gaps_seen),
    .bin_count     (bin_count)
  );

endmodule
